// ----- sv/apg_pkg.sv -----
// Shared types, constants and the arctangent table of the arc point generator.
`default_nettype none
package apg_pkg;

  localparam int DIVIDEND_W = 20;
  localparam int DIVISOR_W  = 6;
  localparam int COUNT_W    = 6;

  // 2*pi and friends in Q4.12 and at 2^-24
  localparam logic [17:0] TWO_PI_Q12  = 18'd25736;
  localparam logic [30:0] TWO_PI_Q24  = 31'd105414357;
  localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
  localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
  // pi plus four full turns keeps the angle positive before reduction
  localparam logic signed [31:0] WRAP_OFFSET = 32'sd474364607;
  localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
  // 64 * 16 * 2*pi in Q4.12: at or above this the automatic count saturates
  localparam logic [33:0] AUTO_SAT = 34'd26353664;
  // 16 * 2*pi in Q4.12 is 3217 * 128; ceil(2^30 / 3217) is exact for the
  // products below AUTO_SAT after dropping the 7 low bits
  localparam logic [18:0] AUTO_RECIP = 19'd333772;

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_AUTO, S_STEP_START, S_STEP_WAIT,
    S_ANGLE, S_REDUCE, S_FOLD, S_CORDIC, S_SCALE, S_EMIT, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic prod;
    logic set_n;
    logic div_step;
    logic set_step;
    logic angle;
    logic reduce;
    logic fold;
    logic cordic;
    logic scale;
    logic emit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic req_auto;
    logic div_done;
    logic red_last;
    logic cordic_last;
    logic out_taken;
    logic last;
  } status_t;

  // arctangent of 2^-i at 2^-24
  function automatic logic [23:0] atan_q24(input logic [4:0] i);
    logic [23:0] v;
    case (i)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047215;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262124;
      5'd7:  v = 24'd131070;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/apg_divider.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module apg_divider (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [apg_pkg::DIVIDEND_W-1:0]      dividend,
  input  wire logic [apg_pkg::DIVISOR_W-1:0]       divisor,
  output logic      [apg_pkg::DIVIDEND_W-1:0]      quotient,
  output logic                                     done
);
  logic [apg_pkg::DIVISOR_W:0]     rem;
  logic [apg_pkg::DIVISOR_W-1:0]   dvs;
  logic [apg_pkg::DIVIDEND_W-1:0]  q;
  logic [5:0]                      cnt;
  logic                            busy;
  logic [apg_pkg::DIVISOR_W:0]     trial;
  logic                            fits;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem[apg_pkg::DIVISOR_W-1:0], q[apg_pkg::DIVIDEND_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(apg_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      q   <= dividend;
    end else if (busy) begin
      rem <= fits ? trial - {1'b0, dvs} : trial;
      q   <= {q[apg_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = q;
endmodule
`default_nettype wire

// ----- sv/apg_datapath.sv -----
// Datapath: request latch, segment count and step division, angle reduction,
// CORDIC and scaling to the output registers.
`default_nettype none
module apg_datapath #(
  parameter int MAX_SEGMENTS      = 63,
  parameter int MIN_AUTO_SEGMENTS = 10,
  parameter int CORDIC_STEPS      = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire apg_pkg::cmd_t       cmd,
  output apg_pkg::status_t         status,
  input  wire logic signed [19:0]  center_x,
  input  wire logic signed [19:0]  center_y,
  input  wire logic [15:0]         radius,
  input  wire logic signed [15:0]  start_angle,
  input  wire logic signed [15:0]  end_angle,
  input  wire logic [5:0]          segment_count,
  output logic signed [19:0]       point_x,
  output logic signed [19:0]       point_y,
  output logic                     last_point,
  output logic                     out_valid,
  input  wire logic                out_stall
);
  logic signed [19:0] cx, cy;
  logic [15:0]        r;
  logic signed [15:0] a1;
  logic [15:0]        span;
  logic [5:0]         req;
  logic [33:0]        prod;
  logic [5:0]         n;
  logic [19:0]        step;
  logic [19:0]        acc;
  logic [5:0]         idx;
  logic [30:0]        w;
  logic [1:0]         rcnt;
  logic signed [27:0] z;
  logic signed [32:0] x, y;
  logic               neg;
  logic [4:0]         ci;
  logic signed [49:0] mx, my;

  logic signed [16:0] d17;
  logic signed [17:0] sp18;
  logic [5:0]         req_n;
  logic [31:0]        rspan;
  logic               div_start;
  logic [19:0]        div_dividend;
  logic [5:0]         div_divisor;
  logic [19:0]        div_q;
  logic               div_done;
  logic [36:0]        auto_mul;
  logic [6:0]         auto_q;
  logic [6:0]         q_min;
  logic [5:0]         n_auto;
  logic signed [17:0] theta;
  logic signed [31:0] zt;
  logic [30:0]        modulus;
  logic signed [31:0] zf;
  logic signed [32:0] xs, ys, xn, yn;
  logic signed [27:0] at;
  logic signed [16:0] rs;
  logic signed [49:0] rx, ry;

  // span after raising the end angle by whole turns, and the clamped segment count
  always_comb begin
    d17 = 17'(start_angle) - 17'(end_angle);
    if (d17 <= 17'sd0)
      sp18 = -18'(d17);
    else if (d17 <= 17'sd25736)
      sp18 = $signed(apg_pkg::TWO_PI_Q12) - 18'(d17);
    else if (d17 <= 17'sd51472)
      sp18 = 18'sd51472 - 18'(d17);
    else
      sp18 = 18'sd77208 - 18'(d17);
    if (segment_count > 6'(MAX_SEGMENTS))
      req_n = 6'(MAX_SEGMENTS);
    else
      req_n = segment_count;
  end

  // step divider operands and the radius-span product
  always_comb begin
    rspan        = r * span;
    div_start    = cmd.div_step;
    div_dividend = {span, 4'd0};
    div_divisor  = n;
  end

  apg_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  // automatic count: reciprocal multiply, then clamp
  always_comb begin
    auto_mul = prod[24:7] * apg_pkg::AUTO_RECIP;
    auto_q   = auto_mul[36:30];
    q_min    = (auto_q < 7'(MIN_AUTO_SEGMENTS)) ? 7'(MIN_AUTO_SEGMENTS) : auto_q;
    if (prod >= apg_pkg::AUTO_SAT || q_min > 7'(MAX_SEGMENTS))
      n_auto = 6'(MAX_SEGMENTS);
    else
      n_auto = q_min[5:0];
  end

  // angle, reduction and CORDIC terms
  always_comb begin
    theta   = 18'(a1) + $signed({2'b00, acc[19:4]});
    zt      = {{2{theta[17]}}, theta, 12'd0};
    modulus = apg_pkg::TWO_PI_Q24 << rcnt;
    zf      = $signed({1'b0, w}) - apg_pkg::PI_Q24;
    xs      = x >>> ci;
    ys      = y >>> ci;
    at      = $signed({4'd0, apg_pkg::atan_q24(ci)});
    xn      = neg ? -x : x;
    yn      = neg ? -y : y;
    rs      = $signed({1'b0, r});
    rx      = (mx + 50'sd536870912) >>> 30;
    ry      = (my + 50'sd536870912) >>> 30;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx   <= center_x;
      cy   <= center_y;
      r    <= radius;
      a1   <= start_angle;
      span <= sp18[15:0];
      req  <= segment_count;
      n    <= req_n;
      acc  <= '0;
      idx  <= '0;
    end
    if (cmd.prod)
      prod <= {2'b00, rspan} + {1'b0, rspan, 1'b0};
    if (cmd.set_n)
      n <= n_auto;
    if (cmd.set_step)
      step <= div_q;
    if (cmd.angle) begin
      w    <= 31'(zt + apg_pkg::WRAP_OFFSET);
      rcnt <= 2'd3;
    end
    if (cmd.reduce) begin
      if (w >= modulus)
        w <= w - modulus;
      rcnt <= rcnt - 2'd1;
    end
    if (cmd.fold) begin
      x  <= apg_pkg::GAIN_Q30;
      y  <= '0;
      ci <= '0;
      if (zf > apg_pkg::HALF_PI_Q24) begin
        z   <= 28'(zf - apg_pkg::PI_Q24);
        neg <= 1'b1;
      end else if (zf < -apg_pkg::HALF_PI_Q24) begin
        z   <= 28'(zf + apg_pkg::PI_Q24);
        neg <= 1'b1;
      end else begin
        z   <= 28'(zf);
        neg <= 1'b0;
      end
    end
    if (cmd.cordic) begin
      ci <= ci + 5'd1;
      if (z >= 28'sd0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
    if (cmd.scale) begin
      mx <= rs * xn;
      my <= rs * yn;
    end
    if (cmd.emit) begin
      point_x    <= cx + 20'(rx);
      point_y    <= cy + 20'(ry);
      last_point <= idx == n;
    end
    if (cmd.advance) begin
      acc <= acc + step;
      idx <= idx + 6'd1;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (cmd.emit)
      out_valid <= 1'b1;
    else if (!out_stall)
      out_valid <= 1'b0;
  end

  always_comb begin
    status.req_auto    = req == 6'd0;
    status.div_done    = div_done;
    status.red_last    = rcnt == 2'd0;
    status.cordic_last = ci == 5'(CORDIC_STEPS - 1);
    status.out_taken   = out_valid & ~out_stall;
    status.last        = idx == n;
  end
endmodule
`default_nettype wire

// ----- sv/apg_ctrl.sv -----
// Controller state machine sequencing the datapath.
`default_nettype none
module apg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire apg_pkg::status_t  status,
  output apg_pkg::cmd_t          cmd,
  output logic                   idle
);
  apg_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst)
      state <= apg_pkg::S_IDLE;
    else
      state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      apg_pkg::S_IDLE:       if (in_valid) state_next = apg_pkg::S_PROD;
      apg_pkg::S_PROD:       state_next = status.req_auto ? apg_pkg::S_AUTO
                                                          : apg_pkg::S_STEP_START;
      apg_pkg::S_AUTO:       state_next = apg_pkg::S_STEP_START;
      apg_pkg::S_STEP_START: state_next = apg_pkg::S_STEP_WAIT;
      apg_pkg::S_STEP_WAIT:  if (status.div_done) state_next = apg_pkg::S_ANGLE;
      apg_pkg::S_ANGLE:      state_next = apg_pkg::S_REDUCE;
      apg_pkg::S_REDUCE:     if (status.red_last) state_next = apg_pkg::S_FOLD;
      apg_pkg::S_FOLD:       state_next = apg_pkg::S_CORDIC;
      apg_pkg::S_CORDIC:     if (status.cordic_last) state_next = apg_pkg::S_SCALE;
      apg_pkg::S_SCALE:      state_next = apg_pkg::S_EMIT;
      apg_pkg::S_EMIT:       state_next = apg_pkg::S_OUT;
      apg_pkg::S_OUT: begin
        if (status.out_taken)
          state_next = status.last ? apg_pkg::S_IDLE : apg_pkg::S_ANGLE;
      end
      default:               state_next = apg_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    case (state)
      apg_pkg::S_IDLE: begin
        idle     = 1'b1;
        cmd.load = in_valid;
      end
      apg_pkg::S_PROD:       cmd.prod = 1'b1;
      apg_pkg::S_AUTO:       cmd.set_n = 1'b1;
      apg_pkg::S_STEP_START: cmd.div_step = 1'b1;
      apg_pkg::S_STEP_WAIT:  cmd.set_step = status.div_done;
      apg_pkg::S_ANGLE:      cmd.angle = 1'b1;
      apg_pkg::S_REDUCE:     cmd.reduce = 1'b1;
      apg_pkg::S_FOLD:       cmd.fold = 1'b1;
      apg_pkg::S_CORDIC:     cmd.cordic = 1'b1;
      apg_pkg::S_SCALE:      cmd.scale = 1'b1;
      apg_pkg::S_EMIT:       cmd.emit = 1'b1;
      apg_pkg::S_OUT:        cmd.advance = status.out_taken & ~status.last;
      default:               cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/arc_point_generator.sv -----
// Arc point generator: takes one arc request (center, radius, start and end
// angle, segment count) and emits segments+1 polyline vertices, the last one
// flagged. One request is worked at a time; in_stall is high during reset and
// from acceptance until the last vertex is taken. After acceptance, setup runs
// the product, the automatic count by reciprocal multiply (taken only for a
// zero segment count), then the 20-bit step division, one quotient bit per
// cycle plus start and finish. Each vertex then runs the angle, four
// reduction steps, fold, one CORDIC iteration per cycle, scale, emit and an
// output state held while the output is stalled. An idle state follows the
// arc.
`default_nettype none
module arc_point_generator #(
  parameter int MAX_SEGMENTS      = 63,
  parameter int MIN_AUTO_SEGMENTS = 10,
  parameter int CORDIC_STEPS      = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [19:0] center_x,
  input  wire logic signed [19:0] center_y,
  input  wire logic [15:0]        radius,
  input  wire logic signed [15:0] start_angle,
  input  wire logic signed [15:0] end_angle,
  input  wire logic [5:0]         segment_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [19:0]      point_x,
  output logic signed [19:0]      point_y,
  output logic                    last_point
);
  apg_pkg::cmd_t    cmd;
  apg_pkg::status_t status;
  logic             idle;

  apg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .idle     (idle)
  );

  apg_datapath #(
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .MIN_AUTO_SEGMENTS (MIN_AUTO_SEGMENTS),
    .CORDIC_STEPS      (CORDIC_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .center_x      (center_x),
    .center_y      (center_y),
    .radius        (radius),
    .start_angle   (start_angle),
    .end_angle     (end_angle),
    .segment_count (segment_count),
    .point_x       (point_x),
    .point_y       (point_y),
    .last_point    (last_point),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

  assign in_stall = ~idle | rst;
endmodule
`default_nettype wire
